// ===== design/assert_macros.svh =====
// Assertion macros shared by the retransmit window tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rwt_pkg.sv =====
// Shared constants, codes and control/status types of the retransmit window tracker.
package rwt_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

  localparam int SEQ_W  = 32;
  localparam int TIME_W = 32;
  localparam int TMO_W  = 16;
  localparam int MODE_W = 2;
  localparam int KIND_W = 2;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd1000;

  // input item modes
  localparam logic [MODE_W-1:0] MODE_SEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_TRANSMIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETRANSMIT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL       = 2'd2;

  typedef struct packed {
    logic capture;      // latch the input beat
    logic send;         // append (or reject) and emit one result
    logic ack_cmp;      // compare window against acked seq
    logic ack_shift;    // remove first match, compact
    logic flush_start;  // clear the resend index
    logic flush_step;   // emit one retransmit, restamp that entry
  } ctrl_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              empty;
    logic              late;
    logic              slot_free;
    logic              flush_last;
  } dp_stat_t;

endpackage

// ===== design/rwt_in_if.sv =====
// Input channel of the retransmit window tracker: valid/ready plus item payload.
interface rwt_in_if;
  logic                       valid;
  logic                       ready;
  logic [rwt_pkg::MODE_W-1:0] mode;
  logic [rwt_pkg::SEQ_W-1:0]  seq_id;
  logic [rwt_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, mode, seq_id, now_ms, input ready);
  modport sink   (input valid, mode, seq_id, now_ms, output ready);
endinterface

// ===== design/rwt_out_if.sv =====
// Result channel of the retransmit window tracker: valid/ready plus result payload.
interface rwt_out_if;
  logic                       valid;
  logic                       ready;
  logic [rwt_pkg::KIND_W-1:0] kind;
  logic [rwt_pkg::SEQ_W-1:0]  out_seq;
  logic                       last;

  modport source (output valid, kind, out_seq, last, input ready);
  modport sink   (input valid, kind, out_seq, last, output ready);
endinterface

// ===== design/retransmit_window_tracker_unit.sv =====
// A send is captured, then executed, loading its transmit/full beat into the result register
// (waiting in exec while out stalls); an ack compares, then compacts, with no beat; a tick that
// is not late gives none. A new item is taken only back in idle; a late tick holds the input
// for its resend sweep, one retransmit beat per cycle off the single result register, fewer
// while out stalls. Reset: rst_n synchronous, active low; empties the window, sets timeout to
// 1000 ms, drops any pending result. Window storage is not cleared; only filled entries are used.
module retransmit_window_tracker_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  rwt_in_if.sink                    in_ch,
  rwt_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [rwt_pkg::TMO_W-1:0] cfg_wdata
);

  rwt_pkg::ctrl_cmd_t cmd;
  rwt_pkg::dp_stat_t  stat;
  logic               in_ready_w;

  // Controller: idle -> exec, then back to idle, or via ack compaction or a per-entry resend sweep.
  // Input is held off while reset is asserted.
  rwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready_w),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready_w;

  // Datapath: window registers, parallel ack compare, age check, result register.
  rwt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_mode   (in_ch.mode),
    .in_seq_id (in_ch.seq_id),
    .in_now_ms (in_ch.now_ms),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

// ===== design/rwt_ctrl.sv =====
// Controller state machine of the retransmit window tracker.
`include "assert_macros.svh"

module rwt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rwt_pkg::dp_stat_t  stat,
  output rwt_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SHIFT, S_FLUSH} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = rst_n && (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.mode)
          rwt_pkg::MODE_SEND: begin
            if (stat.slot_free) begin
              cmd.send  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          rwt_pkg::MODE_ACK: begin
            cmd.ack_cmp = 1'b1;
            state_nxt   = S_SHIFT;
          end
          rwt_pkg::MODE_TICK: begin
            if (!stat.empty && stat.late) begin
              cmd.flush_start = 1'b1;
              state_nxt       = S_FLUSH;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SHIFT: begin
        cmd.ack_shift = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_FLUSH: begin
        if (stat.slot_free) begin
          cmd.flush_step = 1'b1;
          if (stat.flush_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_NEXT(a_shift_follows_cmp, clk, rst_n, cmd.ack_cmp, state_r == S_SHIFT, "ack compaction did not follow compare")
  `ASSERT_IMPL(a_flush_only_nonempty, clk, rst_n, cmd.flush_start, !stat.empty && stat.mode == rwt_pkg::MODE_TICK, "resend started without a late tick on a filled window")

endmodule

// ===== design/rwt_dp.sv =====
// Datapath of the retransmit window tracker: window storage, compare, age check, result register.
`include "assert_macros.svh"

module rwt_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rwt_pkg::ctrl_cmd_t         cmd,
  output rwt_pkg::dp_stat_t          stat,
  input  logic [rwt_pkg::MODE_W-1:0] in_mode,
  input  logic [rwt_pkg::SEQ_W-1:0]  in_seq_id,
  input  logic [rwt_pkg::TIME_W-1:0] in_now_ms,
  input  logic                       cfg_we,
  input  logic [rwt_pkg::TMO_W-1:0]  cfg_wdata,
  rwt_out_if.source                  out_ch
);

  // captured item
  logic [rwt_pkg::MODE_W-1:0] mode_r;
  logic [rwt_pkg::SEQ_W-1:0]  seq_r;
  logic [rwt_pkg::TIME_W-1:0] now_r;

  // window storage, oldest at index 0
  logic [rwt_pkg::SEQ_W-1:0]  entry_seq_r  [rwt_pkg::WINDOW_DEPTH];
  logic [rwt_pkg::TIME_W-1:0] entry_time_r [rwt_pkg::WINDOW_DEPTH];
  logic [rwt_pkg::CNT_W-1:0]  count_r;

  logic [rwt_pkg::TMO_W-1:0]  timeout_r;
  logic                       hit_r;
  logic [rwt_pkg::IDX_W-1:0]  pos_r;
  logic [rwt_pkg::IDX_W-1:0]  flush_idx_r;

  logic                       out_valid_r;
  logic [rwt_pkg::KIND_W-1:0] out_kind_r;
  logic [rwt_pkg::SEQ_W-1:0]  out_seq_r;
  logic                       out_last_r;

  logic                              full;
  logic                              empty;
  logic [rwt_pkg::TIME_W-1:0]        age;
  logic                              late;
  logic                              slot_free;
  logic                              flush_last;
  logic [rwt_pkg::WINDOW_DEPTH-1:0]  match;
  logic                              hit;
  logic [rwt_pkg::IDX_W-1:0]         pos;
  logic [rwt_pkg::IDX_W-1:0]         wr_idx;

  assign full       = (count_r == rwt_pkg::CNT_W'(rwt_pkg::WINDOW_DEPTH));
  assign empty      = (count_r == '0);
  assign age        = now_r - entry_time_r[0];
  assign late       = (age > rwt_pkg::TIME_W'(timeout_r));
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign flush_last = ((rwt_pkg::CNT_W'(flush_idx_r) + rwt_pkg::CNT_W'(1)) == count_r);
  assign wr_idx     = count_r[rwt_pkg::IDX_W-1:0];

  // parallel compare against live entries, lowest match wins
  always_comb begin
    for (int i = 0; i < rwt_pkg::WINDOW_DEPTH; i++) begin
      match[i] = (rwt_pkg::CNT_W'(i) < count_r) && (entry_seq_r[i] == seq_r);
    end
    hit = |match;
    pos = '0;
    for (int i = rwt_pkg::WINDOW_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = rwt_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    stat.mode       = mode_r;
    stat.empty      = empty;
    stat.late       = late;
    stat.slot_free  = slot_free;
    stat.flush_last = flush_last;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      seq_r  <= in_seq_id;
      now_r  <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send && !full) begin
      entry_seq_r[wr_idx]  <= seq_r;
      entry_time_r[wr_idx] <= now_r;
    end
    if (cmd.ack_shift && hit_r) begin
      for (int j = 0; j < rwt_pkg::WINDOW_DEPTH - 1; j++) begin
        if (rwt_pkg::IDX_W'(j) >= pos_r) begin
          entry_seq_r[j]  <= entry_seq_r[j+1];
          entry_time_r[j] <= entry_time_r[j+1];
        end
      end
    end
    if (cmd.flush_step) begin
      entry_time_r[flush_idx_r] <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      timeout_r   <= rwt_pkg::TIMEOUT_RESET;
      hit_r       <= 1'b0;
      pos_r       <= '0;
      flush_idx_r <= '0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (cmd.send && !full) begin
        count_r <= count_r + rwt_pkg::CNT_W'(1);
      end else if (cmd.ack_shift && hit_r) begin
        count_r <= count_r - rwt_pkg::CNT_W'(1);
      end
      if (cmd.ack_cmp) begin
        hit_r <= hit;
        pos_r <= pos;
      end
      if (cmd.flush_start) begin
        flush_idx_r <= '0;
      end else if (cmd.flush_step) begin
        flush_idx_r <= flush_idx_r + rwt_pkg::IDX_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.send || cmd.flush_step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      out_kind_r <= full ? rwt_pkg::KIND_FULL : rwt_pkg::KIND_TRANSMIT;
      out_seq_r  <= seq_r;
      out_last_r <= 1'b1;
    end else if (cmd.flush_step) begin
      out_kind_r <= rwt_pkg::KIND_RETRANSMIT;
      out_seq_r  <= entry_seq_r[flush_idx_r];
      out_last_r <= flush_last;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.kind    = out_kind_r;
  assign out_ch.out_seq = out_seq_r;
  assign out_ch.last    = out_last_r;

  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= rwt_pkg::CNT_W'(rwt_pkg::WINDOW_DEPTH), "window count above depth")
  `ASSERT_NEXT(a_send_grows, clk, rst_n, cmd.send && !full, count_r == $past(count_r) + rwt_pkg::CNT_W'(1), "accepted send did not grow window")
  `ASSERT_IMPL(a_load_has_slot, clk, rst_n, cmd.send || cmd.flush_step, slot_free, "result loaded over an untaken result")

endmodule
